### rtl/fpfl_pkg.sv
package fpfl_pkg;

  localparam int INDEX_W   = 12;
  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 13;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_USED = 2'd1;

  localparam logic [ADDR_W-1:0]  FRAME_BYTES   = 32'h0000_0680;
  localparam logic [ADDR_W-1:0]  ADDR_LIMIT    = 32'h8000_0000;
  localparam logic [COUNT_W-1:0] FRAMES_RESET  = 13'd4096;

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_ALLOC,
    RES_FREE
  } res_kind_t;

  typedef struct packed {
    logic      capture;
    logic      init_start;
    logic      init_step;
    logic      alloc_read;
    logic      out_load;
    res_kind_t kind;
  } fpfl_cmd_t;

  typedef struct packed {
    logic init_done;
    logic out_free;
  } fpfl_status_t;

endpackage

### rtl/fpfl_ctrl.sv
module fpfl_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fpfl_pkg::OP_W-1:0]   op,
  input  fpfl_pkg::fpfl_status_t      status,
  output fpfl_pkg::fpfl_cmd_t         cmd
);
  import fpfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_START,
    S_INIT_RUN,
    S_ALLOC_READ,
    S_ALLOC_DONE,
    S_FREE_DONE,
    S_PLAIN_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.kind       = RES_PLAIN;
    cmd.capture    = in_valid && in_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_INIT:  state_next = S_INIT_START;
            OP_ALLOC: state_next = S_ALLOC_READ;
            OP_FREE:  state_next = S_FREE_DONE;
            default:  state_next = S_PLAIN_DONE;
          endcase
        end
      end
      S_INIT_START: begin
        cmd.init_start = 1'b1;
        state_next     = S_INIT_RUN;
      end
      S_INIT_RUN: begin
        if (status.init_done) begin
          state_next = S_PLAIN_DONE;
        end else begin
          cmd.init_step = 1'b1;
        end
      end
      S_ALLOC_READ: begin
        cmd.alloc_read = 1'b1;
        state_next     = S_ALLOC_DONE;
      end
      S_ALLOC_DONE: begin
        cmd.kind = RES_ALLOC;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FREE_DONE: begin
        cmd.kind = RES_FREE;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_PLAIN_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/fpfl_dp.sv
module fpfl_dp #(
  parameter int NUM_FRAMES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fpfl_pkg::fpfl_cmd_t              cmd,
  output fpfl_pkg::fpfl_status_t           status,
  input  logic [fpfl_pkg::INDEX_W-1:0]     freed_index,
  input  logic                             cfg_write,
  input  logic [fpfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpfl_pkg::ADDR_W-1:0]      cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             granted,
  output logic [fpfl_pkg::INDEX_W-1:0]     frame_index,
  output logic [fpfl_pkg::ADDR_W-1:0]      frame_address,
  output logic                             pool_empty
);
  import fpfl_pkg::*;

  localparam int IDX_W  = $clog2(NUM_FRAMES);
  localparam int HEAD_W = IDX_W + 1;
  localparam logic [HEAD_W-1:0]  EMPTY_MARK = HEAD_W'(NUM_FRAMES);
  localparam logic [COUNT_W-1:0] NUM_FRAMES_C = COUNT_W'(NUM_FRAMES);

  logic [ADDR_W-1:0]  base_addr;
  logic [COUNT_W-1:0] frame_count;
  logic [HEAD_W-1:0]  head, head_next;
  logic [HEAD_W-1:0]  link_mem [NUM_FRAMES];
  logic [HEAD_W-1:0]  rd_link;
  logic [ADDR_W-1:0]  prod;
  logic [HEAD_W-1:0]  init_ptr, init_count;
  logic [INDEX_W-1:0] freed_reg;
  logic [ADDR_W-1:0]  addr_sum;
  logic               head_empty, grant_ok, free_ok;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;

  assign head_empty = (head >= EMPTY_MARK);
  assign addr_sum   = base_addr + prod;
  assign grant_ok   = !head_empty && (addr_sum < ADDR_LIMIT);
  assign free_ok    = (COUNT_W'(freed_reg) < NUM_FRAMES_C);

  assign status.init_done = (init_ptr == init_count);
  assign status.out_free  = !out_valid || out_ready;

  assign mem_we    = cmd.init_step || (cmd.out_load && cmd.kind == RES_FREE && free_ok);
  assign mem_waddr = cmd.init_step ? init_ptr[IDX_W-1:0] : freed_reg[IDX_W-1:0];

  always_comb begin
    head_next = head;
    if (cmd.init_start) begin
      head_next = EMPTY_MARK;
    end else if (cmd.init_step) begin
      head_next = init_ptr;
    end else if (cmd.out_load) begin
      case (cmd.kind)
        RES_ALLOC: if (grant_ok) head_next = rd_link;
        RES_FREE:  if (free_ok) head_next = HEAD_W'(freed_reg);
        default:   head_next = head;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= head;
    end
    if (cmd.alloc_read && !head_empty) begin
      rd_link <= link_mem[head[IDX_W-1:0]];
    end
    if (cmd.alloc_read) begin
      prod <= ADDR_W'(head[IDX_W-1:0]) * FRAME_BYTES;
    end
    if (cmd.capture) begin
      freed_reg <= freed_index;
    end
    if (cmd.out_load) begin
      pool_empty <= (head_next >= EMPTY_MARK);
      if (cmd.kind == RES_ALLOC && grant_ok) begin
        granted       <= 1'b1;
        frame_index   <= INDEX_W'(head[IDX_W-1:0]);
        frame_address <= addr_sum;
      end else begin
        granted       <= 1'b0;
        frame_index   <= '0;
        frame_address <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= EMPTY_MARK;
      init_ptr    <= '0;
      init_count  <= '0;
      base_addr   <= '0;
      frame_count <= FRAMES_RESET;
      out_valid   <= 1'b0;
    end else begin
      head <= head_next;
      if (cmd.init_start) begin
        init_ptr   <= '0;
        init_count <= (frame_count > NUM_FRAMES_C) ? EMPTY_MARK : HEAD_W'(frame_count);
      end else if (cmd.init_step) begin
        init_ptr <= init_ptr + HEAD_W'(1);
      end
      if (cfg_write && cfg_index == CFG_POOL_BASE) begin
        base_addr <= cfg_data;
      end
      if (cfg_write && cfg_index == CFG_FRAMES_USED) begin
        frame_count <= cfg_data[COUNT_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/frame_pool_free_list_unit.sv
// Fixed-size frame buffer pool kept as a last-in first-out free list of
// frame indices, held in a head register and a one-port link memory with
// one entry per frame. Each input beat yields exactly one result beat. An
// allocate takes longer than a free or an unused opcode because the link
// read of the head frame is registered and the address product is
// registered before the base add, and an init writes one link entry per
// cycle up to the clamped frame count before its result. The link memory
// has no reset; reset leaves the pool empty, so run an init or free frames
// before allocating. A new beat is accepted while the previous result
// still waits on the output.
module frame_pool_free_list_unit #(
  parameter int NUM_FRAMES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fpfl_pkg::OP_W-1:0]        op,
  input  logic [fpfl_pkg::INDEX_W-1:0]     freed_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             granted,
  output logic [fpfl_pkg::INDEX_W-1:0]     frame_index,
  output logic [fpfl_pkg::ADDR_W-1:0]      frame_address,
  output logic                             pool_empty,
  input  logic                             cfg_write,
  input  logic [fpfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpfl_pkg::ADDR_W-1:0]      cfg_data
);
  import fpfl_pkg::*;

  fpfl_cmd_t    cmd;
  fpfl_status_t status;

  fpfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  fpfl_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .freed_index   (freed_index),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted       (granted),
    .frame_index   (frame_index),
    .frame_address (frame_address),
    .pool_empty    (pool_empty)
  );

  // One beat is in flight at a time.
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in flight");

  // A result is loaded only into a free output slot.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  // The init walk stops at the frame count.
  a_init_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.init_step |-> !status.init_done)
    else $error("init wrote past the frame count");

  // No datapath work runs while the block waits for input.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.init_step && !cmd.alloc_read && !cmd.out_load)
    else $error("datapath command issued while idle");

endmodule
